@@ rtl/jsesc_pkg.sv @@
// Shared types, character codes and helpers for the JSON string escaper.
package jsesc_pkg;

	// Queue depth used unless the top level overrides it.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Most bytes a single item can cause, and the width of a byte position.
	localparam int MAX_RESULTS = 14;
	localparam int POS_W       = 4;

	// Field widths on the streams.
	localparam int CP_W     = 21;
	localparam int CHAR_W   = 7;
	localparam int S_DATA_W = 24;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 8;

	// ASCII codes used by the encoder.
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h22;
	localparam logic [CHAR_W-1:0] CH_SLASH  = 7'h2F;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
	localparam logic [CHAR_W-1:0] CH_LOW_B  = 7'h62;
	localparam logic [CHAR_W-1:0] CH_LOW_F  = 7'h66;
	localparam logic [CHAR_W-1:0] CH_LOW_N  = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_LOW_R  = 7'h72;
	localparam logic [CHAR_W-1:0] CH_LOW_T  = 7'h74;
	localparam logic [CHAR_W-1:0] CH_LOW_U  = 7'h75;

	// Control characters that have a two-character escape.
	localparam logic [CP_W-1:0] CP_BS  = 21'h00008;
	localparam logic [CP_W-1:0] CP_TAB = 21'h00009;
	localparam logic [CP_W-1:0] CP_LF  = 21'h0000A;
	localparam logic [CP_W-1:0] CP_FF  = 21'h0000C;
	localparam logic [CP_W-1:0] CP_CR  = 21'h0000D;

	// Printable range and supplementary plane base.
	localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h00020;
	localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h0007E;
	localparam logic [CP_W-1:0] CP_SUPP     = 21'h10000;

	// Upper six bits of the high and low surrogates.
	localparam logic [5:0] SURR_HI_TAG = 6'b110110;
	localparam logic [5:0] SURR_LO_TAG = 6'b110111;

	// Body lengths in bytes for each kind of character.
	localparam logic [POS_W-1:0] LEN_NONE  = 4'd0;
	localparam logic [POS_W-1:0] LEN_PLAIN = 4'd1;
	localparam logic [POS_W-1:0] LEN_SHORT = 4'd2;
	localparam logic [POS_W-1:0] LEN_U16   = 4'd6;
	localparam logic [POS_W-1:0] LEN_PAIR  = 4'd12;

	// Byte positions inside one \uXXXX escape.
	localparam logic [POS_W-1:0] U_POS_BSLASH = 4'd0;
	localparam logic [POS_W-1:0] U_POS_U      = 4'd1;
	localparam logic [POS_W-1:0] U_POS_D3     = 4'd2;
	localparam logic [POS_W-1:0] U_POS_D2     = 4'd3;
	localparam logic [POS_W-1:0] U_POS_D1     = 4'd4;
	localparam logic [POS_W-1:0] U_POS_D0     = 4'd5;

	// How the body of an item is encoded.
	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_PLAIN,
		BODY_SHORT,
		BODY_U16,
		BODY_PAIR
	} body_kind_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		body_kind_t         kind;
		logic [CHAR_W-1:0]  chr;
		logic [15:0]        hi16;
		logic [15:0]        lo16;
		logic               starts;
		logic [POS_W-1:0]   blen;
		logic [POS_W-1:0]   total;
	} desc_t;

	// Lowercase hex digit for one nibble.
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] n7;
		n7 = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_char = 7'h30 + n7;
		end else begin
			hex_char = 7'h57 + n7;
		end
	endfunction

endpackage

@@ rtl/jsesc_front.sv @@
// Front part: holds the configuration register and classifies each input item.
module jsesc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [jsesc_pkg::S_DATA_W-1:0] s_axis_tdata,
	input  logic [jsesc_pkg::S_USER_W-1:0] s_axis_tuser,
	input  logic                           s_axis_tlast,
	output logic                           push,
	output jsesc_pkg::desc_t               push_desc,
	input  logic                           push_ready
);
	import jsesc_pkg::*;

	logic             split_q;
	logic [CP_W-1:0]  cp;
	logic [CP_W-1:0]  offset;
	logic             starts;
	logic             ends;
	logic             empty;
	logic             printable;
	desc_t            d;

	// Surrogate-pair register; the user must write it only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q <= 1'b1;
		end else if (cfg_wr_en) begin
			split_q <= cfg_wr_data;
		end
	end

	assign cp     = s_axis_tdata[CP_W-1:0];
	assign starts = s_axis_tuser[0];
	assign empty  = s_axis_tuser[1];
	assign ends   = s_axis_tlast;
	assign offset = cp - CP_SUPP;

	assign printable = (cp >= CP_PRINT_LO) && (cp <= CP_PRINT_HI);

	// Sort the code point into plain, short escape, single or paired \u escape, or no body if empty.
	always_comb begin
		d        = '0;
		d.kind   = BODY_NONE;
		d.chr    = cp[CHAR_W-1:0];
		d.hi16   = cp[15:0];
		d.lo16   = {SURR_LO_TAG, offset[9:0]};
		d.starts = starts;
		d.blen   = LEN_NONE;
		if (empty) begin
			d.starts = 1'b1;
		end else begin
			case (cp) inside
				CP_BS, CP_TAB, CP_LF, CP_FF, CP_CR: begin
					d.kind = BODY_SHORT;
					d.blen = LEN_SHORT;
					case (cp)
						CP_BS:   d.chr = CH_LOW_B;
						CP_TAB:  d.chr = CH_LOW_T;
						CP_LF:   d.chr = CH_LOW_N;
						CP_FF:   d.chr = CH_LOW_F;
						default: d.chr = CH_LOW_R;
					endcase
				end
				{14'd0, CH_QUOTE}, {14'd0, CH_SLASH}, {14'd0, CH_BSLASH}: begin
					d.kind = BODY_SHORT;
					d.blen = LEN_SHORT;
				end
				default: begin
					if (printable) begin
						d.kind = BODY_PLAIN;
						d.blen = LEN_PLAIN;
					end else if ((cp >= CP_SUPP) && split_q) begin
						d.kind = BODY_PAIR;
						d.blen = LEN_PAIR;
						d.hi16 = {SURR_HI_TAG, offset[19:10]};
					end else begin
						d.kind = BODY_U16;
						d.blen = LEN_U16;
					end
				end
			endcase
		end
		d.total = {{(POS_W-1){1'b0}}, d.starts} + d.blen
			+ {{(POS_W-1){1'b0}}, (ends | empty)};
	end

	assign push_desc     = d;
	assign push          = s_axis_tvalid && push_ready;
	assign s_axis_tready = push_ready;

endmodule

@@ rtl/jsesc_queue.sv @@
// Short shifting queue of classified items between the front and back parts.
module jsesc_queue #(
	parameter int DEPTH = jsesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsesc_pkg::desc_t push_desc,
	output logic             push_ready,
	output logic             head_valid,
	output jsesc_pkg::desc_t head_desc,
	input  logic             pop
);
	import jsesc_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	desc_t            entry_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] wsel;

	// The head always sits in entry zero; a pop shifts everything down.
	assign wsel = pop ? (count_q - CNT_ONE) : count_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				entry_q[i] <= entry_q[i+1];
			end
		end
		if (push) begin
			entry_q[wsel[IDX_W-1:0]] <= push_desc;
		end
	end

	// Fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push && !pop) begin
			count_q <= count_q + CNT_ONE;
		end else if (pop && !push) begin
			count_q <= count_q - CNT_ONE;
		end
	end

	assign push_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_desc  = entry_q[0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL) else $error("queue fill level beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_FULL)) else $error("push into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0)) else $error("pop from an empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_ONE))
		else $error("fill level missed a transfer");

endmodule

@@ rtl/jsesc_back.sv @@
// Back part: walks the head item byte by byte into the output register.
module jsesc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_valid,
	input  jsesc_pkg::desc_t               head_desc,
	output logic                           pop,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [jsesc_pkg::M_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);
	import jsesc_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  bidx;
	logic [POS_W-1:0]  sub;
	logic [15:0]       word;
	logic [CHAR_W-1:0] body_byte;
	logic [CHAR_W-1:0] cur_byte;
	logic              cur_last;
	logic              load;
	logic              take;
	logic              valid_q;
	logic [CHAR_W-1:0] byte_q;
	logic              last_q;

	// Position inside the body, and inside the current \u escape of a pair.
	assign bidx = pos_q - {{(POS_W-1){1'b0}}, head_desc.starts};
	assign sub  = (bidx >= LEN_U16) ? (bidx - LEN_U16) : bidx;
	assign word = (bidx >= LEN_U16) ? head_desc.lo16 : head_desc.hi16;

	// Body byte for the current position.
	always_comb begin
		case (head_desc.kind)
			BODY_PLAIN: body_byte = head_desc.chr;
			BODY_SHORT: body_byte = (bidx == '0) ? CH_BSLASH : head_desc.chr;
			BODY_U16, BODY_PAIR: begin
				case (sub)
					U_POS_BSLASH: body_byte = CH_BSLASH;
					U_POS_U:      body_byte = CH_LOW_U;
					U_POS_D3:     body_byte = hex_char(word[15:12]);
					U_POS_D2:     body_byte = hex_char(word[11:8]);
					U_POS_D1:     body_byte = hex_char(word[7:4]);
					default:      body_byte = hex_char(word[3:0]);
				endcase
			end
			default: body_byte = CH_QUOTE;
		endcase
	end

	// Opening quote, body, then closing quote.
	always_comb begin
		if (head_desc.starts && (pos_q == '0)) begin
			cur_byte = CH_QUOTE;
		end else if (bidx < head_desc.blen) begin
			cur_byte = body_byte;
		end else begin
			cur_byte = CH_QUOTE;
		end
	end

	assign cur_last = (pos_q == head_desc.total - {{(POS_W-1){1'b0}}, 1'b1});
	assign load     = !valid_q || m_axis_tready;
	assign take     = load && head_valid;
	assign pop      = take && cur_last;

	// Output register and byte position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= head_valid;
			end
			if (take) begin
				pos_q <= cur_last ? '0 : (pos_q + {{(POS_W-1){1'b0}}, 1'b1});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= cur_byte;
			last_q <= cur_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {{(M_DATA_W-CHAR_W){1'b0}}, byte_q};
	assign m_axis_tlast  = last_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_W'(MAX_RESULTS)) else $error("byte position beyond item");
	a_head_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != '0) |-> head_valid) else $error("item left queue part-way");
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		((pos_q != '0) && !take) |=> $stable(pos_q))
		else $error("byte position moved without a transfer");

endmodule

@@ rtl/json_string_ascii_escaper_unit.sv @@
// The first byte of an item passes through the item queue and then the output register.
// One output byte per cycle while items wait and m_axis_tready is high, through the single
// byte-wide output register fed from the head of the item queue; an item gives 1 to 14 bytes.
// The input side takes one item per cycle while the item queue has room.
// Reset (arst_n low) empties the queue and output register and sets split_supplementary to 1.
module json_string_ascii_escaper_unit #(
	parameter int QUEUE_DEPTH = jsesc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,   // split_supplementary
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [jsesc_pkg::S_DATA_W-1:0] s_axis_tdata,  // code_point[20:0], zero pad
	input  logic [jsesc_pkg::S_USER_W-1:0] s_axis_tuser,  // starts_string, empty_string
	input  logic                           s_axis_tlast,  // ends_string
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [jsesc_pkg::M_DATA_W-1:0] m_axis_tdata,  // out_byte[6:0], zero pad
	output logic                           m_axis_tlast   // last_of_run
);
	import jsesc_pkg::*;

	logic  push;
	logic  push_ready;
	desc_t push_desc;
	logic  head_valid;
	desc_t head_desc;
	logic  pop;

	// Classification of incoming items.
	jsesc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.push          (push),
		.push_desc     (push_desc),
		.push_ready    (push_ready)
	);

	// Item queue between the two parts.
	jsesc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop)
	);

	// Byte sequencer and output register.
	jsesc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head_desc     (head_desc),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
